// ----- rtl/cbc_pkg.sv -----
`default_nettype none

package cbc_pkg;

    localparam int CBC_COORD_BITS = 10;
    localparam int POS_W          = 10;
    localparam int CHAN_W         = 8;
    localparam int COUNT_W        = 21;
    localparam int CENT_W         = 14;
    localparam int COLOUR_W       = 3;
    localparam int NUM_CLASSES    = 6;
    localparam int IDX_W          = 3;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 8;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 80;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARK      = 1'd1;

    localparam logic [CHAN_W-1:0] THRESHOLD_RST = 8'd163;
    localparam logic [CHAN_W-1:0] MARK_RST      = 8'd128;

    localparam logic [COLOUR_W-1:0] COL_RED     = 3'd0;
    localparam logic [COLOUR_W-1:0] COL_GREEN   = 3'd1;
    localparam logic [COLOUR_W-1:0] COL_YELLOW  = 3'd2;
    localparam logic [COLOUR_W-1:0] COL_BLUE    = 3'd3;
    localparam logic [COLOUR_W-1:0] COL_CYAN    = 3'd4;
    localparam logic [COLOUR_W-1:0] COL_MAGENTA = 3'd5;
    localparam logic [COLOUR_W-1:0] COL_NONE    = 3'd7;

    localparam logic [COLOUR_W-1:0] COL_LAST = COL_MAGENTA;

    // yellow, green, red, blue, cyan, magenta in that priority
    function automatic logic [COLOUR_W-1:0] classify(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] thr
    );
        logic rs, gs, bs, rz, gz, bz;
        logic [COLOUR_W-1:0] c;
        rs = (r >= thr);
        gs = (g >= thr);
        bs = (b >= thr);
        rz = (r == '0);
        gz = (g == '0);
        bz = (b == '0);
        priority if (rs && gs && bz) c = COL_YELLOW;
        else if (rz && gs && bz)     c = COL_GREEN;
        else if (rs && gz && bz)     c = COL_RED;
        else if (rz && gz && bs)     c = COL_BLUE;
        else if (rz && gs && bs)     c = COL_CYAN;
        else if (rs && gz && bs)     c = COL_MAGENTA;
        else                         c = COL_NONE;
        return c;
    endfunction

    // mark pattern: bit 2 red, bit 1 green, bit 0 blue
    function automatic logic [2:0] mark_of(input logic [COLOUR_W-1:0] c);
        logic [2:0] m;
        unique case (c)
            COL_RED:     m = 3'b100;
            COL_GREEN:   m = 3'b010;
            COL_YELLOW:  m = 3'b110;
            COL_BLUE:    m = 3'b001;
            COL_CYAN:    m = 3'b011;
            COL_MAGENTA: m = 3'b101;
            default:     m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/colour_blob_centroid_core.sv -----
`default_nettype none

// Colour blob centroid core. Each input beat is one RGB pixel with its column,
// row and an end-of-frame flag (tlast). The pixel is sorted into yellow,
// green, red, blue, cyan or magenta against the threshold register; a matched
// pixel comes back in the mark level, any other pixel unchanged, always as one
// pixel beat (tuser 0). Per colour the core keeps a saturating count and
// column/row sums. On the end-of-frame pixel it follows the pixel beat with one
// report beat (tuser 1) per colour seen, in colour code order, holding the
// centroid as unsigned 10.4 fixed point (truncated, saturated) and the count,
// then clears its accumulators; tlast marks the final beat of each input. A
// matched pixel passes through accept, three accumulate steps on one shared
// saturating adder and one output load that waits out output stalls; an
// unmatched pixel goes from accept straight to the output load. On end of
// frame each colour seen takes a scan step, two runs of the bit-serial divider
// (column, then row) and a report load, and each colour not seen below the last
// one seen takes a scan step. The core is not ready meanwhile.
module colour_blob_centroid_core
    import cbc_pkg::*;
#(
    parameter int COORD_BITS = CBC_COORD_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // red[7:0], green[15:8], blue[23:16], pos_x[33:24], pos_y[43:34]
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                  i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // pix_r[7:0], pix_g[15:8], pix_b[23:16], colour[26:24], cent_x[40:27],
    // cent_y[54:41], count[75:55]
    output logic [M_TDATA_W-1:0]       o_m_axis_tdata,
    // kind[0]
    output logic                       o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);

    localparam int SUM_W = COORD_BITS + 20;
    localparam int QW    = SUM_W + 4;
    localparam int PW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int SAT_I = (COORD_BITS + 4 < CENT_W) ? ((1 << (COORD_BITS + 4)) - 1)
                                                     : ((1 << CENT_W) - 1);
    localparam logic [QW-1:0]    SAT_Q     = QW'(SAT_I);
    localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((64'd1 << COUNT_W) - 1);
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ACC_C = 4'd1;
    localparam logic [3:0] ST_ACC_X = 4'd2;
    localparam logic [3:0] ST_ACC_Y = 4'd3;
    localparam logic [3:0] ST_PIX   = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_DIV_X = 4'd6;
    localparam logic [3:0] ST_DIV_Y = 4'd7;
    localparam logic [3:0] ST_REP   = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [CHAN_W-1:0]   r_thr, r_mark;
    logic [CHAN_W-1:0]   r_red, r_green, r_blue;
    logic [PW-1:0]       r_px, r_py;
    logic                r_eof;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [COUNT_W-1:0]  r_cnt [NUM_CLASSES];
    logic [SUM_W-1:0]    r_sx  [NUM_CLASSES];
    logic [SUM_W-1:0]    r_sy  [NUM_CLASSES];
    logic [CENT_W-1:0]   r_cx, r_cy;

    logic                  r_o_valid;
    logic                  r_o_kind;
    logic                  r_o_last;
    logic [M_TDATA_W-1:0]  r_o_data;

    logic [NUM_CLASSES-1:0] nz;
    logic                   above;
    logic                   out_free;
    logic                   in_acc;
    logic                   clr;
    logic                   o_load;
    logic                   o_kind_n;
    logic                   o_last_n;
    logic [M_TDATA_W-1:0]   o_data_n;

    logic [COUNT_W-1:0] rd_cnt;
    logic [SUM_W-1:0]   rd_sx, rd_sy;
    logic [SUM_W-1:0]   add_a, add_b, add_max, add_res;
    logic [SUM_W:0]     add_sum;

    logic              div_start;
    logic [QW-1:0]     div_num;
    logic              div_done;
    logic [QW-1:0]     div_quot;
    logic [CENT_W-1:0] cent_sat;
    logic [2:0]        mark;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_o_valid || i_m_axis_tready;

    assign rd_cnt = r_cnt[r_idx];
    assign rd_sx  = r_sx[r_idx];
    assign rd_sy  = r_sy[r_idx];

    always_comb begin
        above = 1'b0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            nz[k] = (r_cnt[k] != '0);
            if (nz[k] && (IDX_W'(k) > r_idx)) begin
                above = 1'b1;
            end
        end
    end

    // shared saturating adder
    always_comb begin
        unique case (r_state)
            ST_ACC_X: begin
                add_a   = rd_sx;
                add_b   = SUM_W'(r_px);
                add_max = SUM_MAX;
            end
            ST_ACC_Y: begin
                add_a   = rd_sy;
                add_b   = SUM_W'(r_py);
                add_max = SUM_MAX;
            end
            default: begin
                add_a   = SUM_W'(rd_cnt);
                add_b   = SUM_W'(1);
                add_max = COUNT_MAX;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b};
        add_res = (add_sum > {1'b0, add_max}) ? add_max : add_sum[SUM_W-1:0];
    end

    assign div_start = ((r_state == ST_SCAN) && nz[r_idx])
                    || ((r_state == ST_DIV_X) && div_done);
    assign div_num   = (r_state == ST_SCAN) ? {rd_sx, 4'b0000} : {rd_sy, 4'b0000};
    assign cent_sat  = (div_quot > SAT_Q) ? SAT_Q[CENT_W-1:0] : div_quot[CENT_W-1:0];

    cbc_div #(
        .NUM_W (QW),
        .DEN_W (COUNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (rd_cnt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign mark = mark_of(r_idx);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        clr      = 1'b0;
        o_load   = 1'b0;
        o_kind_n = 1'b0;
        o_last_n = 1'b0;
        o_data_n = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx   = classify(i_s_axis_tdata[7:0], i_s_axis_tdata[15:8],
                                       i_s_axis_tdata[23:16], r_thr);
                    n_state = (n_idx == COL_NONE) ? ST_PIX : ST_ACC_C;
                end
            end
            ST_ACC_C: n_state = ST_ACC_X;
            ST_ACC_X: n_state = ST_ACC_Y;
            ST_ACC_Y: n_state = ST_PIX;
            ST_PIX: begin
                if (out_free) begin
                    o_load   = 1'b1;
                    o_last_n = !r_eof || (nz == '0);
                    if (r_idx == COL_NONE) begin
                        o_data_n = M_TDATA_W'({r_blue, r_green, r_red});
                    end else begin
                        o_data_n = M_TDATA_W'({mark[0] ? r_mark : 8'd0,
                                               mark[1] ? r_mark : 8'd0,
                                               mark[2] ? r_mark : 8'd0});
                    end
                    if (r_eof && (nz != '0)) begin
                        n_idx   = COL_RED;
                        n_state = ST_SCAN;
                    end else begin
                        clr     = r_eof;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (nz[r_idx]) begin
                    n_state = ST_DIV_X;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DIV_X: if (div_done) n_state = ST_DIV_Y;
            ST_DIV_Y: if (div_done) n_state = ST_REP;
            ST_REP: begin
                if (out_free) begin
                    o_load   = 1'b1;
                    o_kind_n = 1'b1;
                    o_last_n = !above;
                    o_data_n = M_TDATA_W'({rd_cnt, r_cy, r_cx, r_idx, 24'd0});
                    if (above) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        clr     = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= COL_NONE;
            r_thr     <= THRESHOLD_RST;
            r_mark    <= MARK_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_THRESHOLD) r_thr <= i_cfg_wdata;
                if (i_cfg_addr == CFG_MARK)      r_mark <= i_cfg_wdata;
            end
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cnt[k] <= '0;
                r_sx[k]  <= '0;
                r_sy[k]  <= '0;
            end
        end else begin
            unique case (r_state)
                ST_ACC_C: r_cnt[r_idx] <= add_res[COUNT_W-1:0];
                ST_ACC_X: r_sx[r_idx]  <= add_res;
                ST_ACC_Y: r_sy[r_idx]  <= add_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red   <= i_s_axis_tdata[7:0];
            r_green <= i_s_axis_tdata[15:8];
            r_blue  <= i_s_axis_tdata[23:16];
            r_px    <= i_s_axis_tdata[24 +: PW];
            r_py    <= i_s_axis_tdata[34 +: PW];
            r_eof   <= i_s_axis_tlast;
        end
        if ((r_state == ST_DIV_X) && div_done) r_cx <= cent_sat;
        if ((r_state == ST_DIV_Y) && div_done) r_cy <= cent_sat;
        if (o_load) begin
            r_o_kind <= o_kind_n;
            r_o_last <= o_last_n;
            r_o_data <= o_data_n;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC_C || r_state == ST_ACC_X || r_state == ST_ACC_Y ||
         r_state == ST_SCAN || r_state == ST_DIV_X || r_state == ST_DIV_Y ||
         r_state == ST_REP) |-> r_idx <= COL_LAST)
        else $error("colour index out of range while in use");

    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> nz != '0)
        else $error("report scan with no colour counted");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_X || r_state == ST_DIV_Y))
        else $error("divider finished outside a divide step");

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && o_last_n && (r_state == ST_REP)) |=> nz == '0)
        else $error("accumulators not cleared after frame report");

endmodule

`default_nettype wire

// ----- rtl/cbc_div.sv -----
`default_nettype none

module cbc_div
    import cbc_pkg::*;
#(
    parameter int NUM_W = CBC_COORD_BITS + 24,
    parameter int DEN_W = COUNT_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with empty step count");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cbc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                kind;
        logic [CHAN_W-1:0]   pix_r;
        logic [CHAN_W-1:0]   pix_g;
        logic [CHAN_W-1:0]   pix_b;
        logic [COLOUR_W-1:0] colour;
        logic [CENT_W-1:0]   cent_x;
        logic [CENT_W-1:0]   cent_y;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data = '0;
    logic                  s_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  m_kind;
    logic                  m_last;

    // predictor state
    logic [CHAN_W-1:0]  thr_q = THRESHOLD_RST;
    logic [CHAN_W-1:0]  mark_q = MARK_RST;
    logic [COUNT_W-1:0] blob_count [NUM_CLASSES];
    logic [29:0]        blob_sum_x [NUM_CLASSES];
    logic [29:0]        blob_sum_y [NUM_CLASSES];
    beat_t              expected_beats [$];

    bit gaps_on = 1'b1;
    int hold_request = 0;
    int hold_left = 0;
    int error_count = 0;
    int cycle_count = 0;

    colour_blob_centroid_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_kind),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver ready, with an optional long hold-off
    always @(posedge clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(gaps_on && $urandom_range(0, 99) < 12);
        end
    end

    function automatic logic [COLOUR_W-1:0] sort_pixel(input logic [CHAN_W-1:0] r,
                                                       input logic [CHAN_W-1:0] g,
                                                       input logic [CHAN_W-1:0] b);
        logic rs, gs, bs, rz, gz, bz;
        rs = r >= thr_q;
        gs = g >= thr_q;
        bs = b >= thr_q;
        rz = r == 0;
        gz = g == 0;
        bz = b == 0;
        if (rs && gs && bz) return COL_YELLOW;
        if (rz && gs && bz) return COL_GREEN;
        if (rs && gz && bz) return COL_RED;
        if (rz && gz && bs) return COL_BLUE;
        if (rz && gs && bs) return COL_CYAN;
        if (rs && gz && bs) return COL_MAGENTA;
        return COL_NONE;
    endfunction

    function automatic logic [29:0] sat_sum(input logic [29:0] a, input logic [POS_W-1:0] v);
        logic [30:0] s;
        s = a + v;
        return s[30] ? '1 : s[29:0];
    endfunction

    function automatic logic [CENT_W-1:0] centroid_fx(input logic [29:0] s,
                                                      input logic [COUNT_W-1:0] n);
        logic [63:0] q;
        q = {30'd0, s, 4'd0} / n;
        return (q > 64'd16383) ? 14'd16383 : q[CENT_W-1:0];
    endfunction

    task automatic clear_blobs();
        for (int i = 0; i < NUM_CLASSES; i++) begin
            blob_count[i] = '0;
            blob_sum_x[i] = '0;
            blob_sum_y[i] = '0;
        end
    endtask

    task automatic predict_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                 input logic [CHAN_W-1:0] b, input logic [POS_W-1:0] x,
                                 input logic [POS_W-1:0] y, input logic eof);
        beat_t pending;
        logic [COLOUR_W-1:0] c;
        pending = '0;
        c = sort_pixel(r, g, b);
        case (c)
            COL_RED:     {pending.pix_r, pending.pix_g, pending.pix_b} = {mark_q, 8'd0, 8'd0};
            COL_GREEN:   {pending.pix_r, pending.pix_g, pending.pix_b} = {8'd0, mark_q, 8'd0};
            COL_YELLOW:  {pending.pix_r, pending.pix_g, pending.pix_b} = {mark_q, mark_q, 8'd0};
            COL_BLUE:    {pending.pix_r, pending.pix_g, pending.pix_b} = {8'd0, 8'd0, mark_q};
            COL_CYAN:    {pending.pix_r, pending.pix_g, pending.pix_b} = {8'd0, mark_q, mark_q};
            COL_MAGENTA: {pending.pix_r, pending.pix_g, pending.pix_b} = {mark_q, 8'd0, mark_q};
            default:     {pending.pix_r, pending.pix_g, pending.pix_b} = {r, g, b};
        endcase
        if (c != COL_NONE) begin
            if (blob_count[c] != '1) blob_count[c] = blob_count[c] + 1'b1;
            blob_sum_x[c] = sat_sum(blob_sum_x[c], x);
            blob_sum_y[c] = sat_sum(blob_sum_y[c], y);
        end
        if (eof) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                if (blob_count[i] != 0) begin
                    expected_beats.push_back(pending);
                    pending = '0;
                    pending.kind = 1'b1;
                    pending.colour = i[COLOUR_W-1:0];
                    pending.cent_x = centroid_fx(blob_sum_x[i], blob_count[i]);
                    pending.cent_y = centroid_fx(blob_sum_y[i], blob_count[i]);
                    pending.count = blob_count[i];
                end
            end
            clear_blobs();
        end
        pending.last = 1'b1;
        expected_beats.push_back(pending);
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic eof);
        logic took;
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 12) begin
                s_valid <= 1'b0;
                @(posedge clk);
            end
        end
        s_valid <= 1'b1;
        s_data <= {4'd0, y, x, b, g, r};
        s_last <= eof;
        do begin
            @(negedge clk);
            took = s_ready;
            @(posedge clk);
        end while (!took);
        predict_pixel(r, g, b, x, y, eof);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CHAN_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD: thr_q = val;
            CFG_MARK:      mark_q = val;
            default:       ;
        endcase
    endtask

    function automatic logic [CHAN_W-1:0] pick_level();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return '0;
        if (sel < 8) return CHAN_W'($urandom_range(thr_q, 255));
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [POS_W-1:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return POS_W'($urandom_range(0, 1023));
    endfunction

    task automatic send_random_frame(input int len);
        logic [CHAN_W-1:0] r, g, b;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                r = CHAN_W'($urandom_range(0, 255));
                g = CHAN_W'($urandom_range(0, 255));
                b = CHAN_W'($urandom_range(0, 255));
            end else begin
                r = pick_level();
                g = pick_level();
                b = pick_level();
            end
            send_pixel(r, g, b, pick_coord(), pick_coord(), k == len - 1);
        end
    endtask

    task automatic test_colour_table();
        send_pixel(8'd163, 8'd163, 8'd0,   10'd0,    10'd0,    1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   10'd1023, 10'd1023, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   10'd1023, 10'd0,    1'b0);
        send_pixel(8'd0,   8'd0,   8'd163, 10'd0,    10'd1023, 1'b0);
        send_pixel(8'd0,   8'd163, 8'd255, 10'd512,  10'd7,    1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 10'd3,    10'd900,  1'b0);
        // just below threshold, and a nonzero channel that is not strong
        send_pixel(8'd162, 8'd0,   8'd0,   10'd100,  10'd200,  1'b0);
        send_pixel(8'd255, 8'd1,   8'd0,   10'd100,  10'd200,  1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   10'd5,    10'd6,    1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 10'd5,    10'd6,    1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   10'd1023, 10'd1023, 1'b0);
        send_pixel(8'd163, 8'd0,   8'd163, 10'd1,    10'd1,    1'b1);
    endtask

    // frame end with no colour seen
    task automatic test_empty_frame();
        send_pixel(8'd10, 8'd20, 8'd30, 10'd700, 10'd300, 1'b0);
        send_pixel(8'd1,  8'd0,  8'd0,  10'd1,   10'd2,   1'b1);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_THRESHOLD, 8'd0);
        write_reg(CFG_MARK, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd0,   10'd1023, 10'd0,    1'b0);
        send_pixel(8'd0,   8'd7,   8'd9,   10'd0,    10'd1023, 1'b0);
        send_pixel(8'd5,   8'd0,   8'd9,   10'd11,   10'd22,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 10'd33,   10'd44,   1'b1);
        drain();
        write_reg(CFG_THRESHOLD, 8'd255);
        write_reg(CFG_MARK, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd0,   10'd1023, 10'd1023, 1'b0);
        send_pixel(8'd254, 8'd0,   8'd0,   10'd50,   10'd60,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 10'd70,   10'd80,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 10'd90,   10'd10,   1'b1);
        drain();
    endtask

    task automatic test_random_frames();
        int sent, len;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       write_reg(CFG_THRESHOLD, 8'd255);
                2:       write_reg(CFG_THRESHOLD, 8'd0);
                default: write_reg(CFG_THRESHOLD, CHAN_W'($urandom_range(1, 254)));
            endcase
            write_reg(CFG_MARK, CHAN_W'($urandom_range(0, 255)));
            // second half of the last phase runs without idling
            sent = 0;
            while (sent < 40) begin
                if (phase == 3 && sent >= 20) gaps_on = 1'b0;
                len = $urandom_range(1, 10);
                send_random_frame(len);
                sent += len;
            end
            gaps_on = 1'b1;
            drain();
        end
    endtask

    // output held off while the input keeps offering beats
    task automatic test_backpressure();
        write_reg(CFG_THRESHOLD, 8'd150);
        write_reg(CFG_MARK, 8'd200);
        gaps_on = 1'b0;
        hold_request = 400;
        send_random_frame(24);
        gaps_on = 1'b1;
        drain();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            if (error_count <= 40)
                $display("%0t %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // output beats are sampled at the falling edge and taken at the next rising one
    always @(negedge clk) begin
        beat_t want;
        if (rst_n && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                error_count++;
                if (error_count <= 40)
                    $display("%0t unexpected beat expected none actual %h", $time, m_data);
            end else begin
                want = expected_beats.pop_front();
                check_field("kind",   want.kind,   m_kind);
                check_field("pix_r",  want.pix_r,  m_data[7:0]);
                check_field("pix_g",  want.pix_g,  m_data[15:8]);
                check_field("pix_b",  want.pix_b,  m_data[23:16]);
                check_field("colour", want.colour, m_data[26:24]);
                check_field("cent_x", want.cent_x, m_data[40:27]);
                check_field("cent_y", want.cent_y, m_data[54:41]);
                check_field("count",  want.count,  m_data[75:55]);
                check_field("last",   want.last,   m_last);
            end
        end
    end

    initial begin
        clear_blobs();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_colour_table();
        test_empty_frame();
        test_register_extremes();
        test_random_frames();
        test_backpressure();
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
